[src/slot_bitmap_allocator_macros.svh]
// ---------------------------------------------------------------------------
// slot_bitmap_allocator assertion macros
// Property check wrappers shared by the allocator modules.
// ---------------------------------------------------------------------------
`ifndef SLOT_BITMAP_ALLOCATOR_MACROS_SVH
`define SLOT_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define SBA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SBA_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SBA_ASSERT(name, clk, rst, prop, msg)
`define SBA_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

[src/sba_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_pkg
// Types, sizes and field layout of the slot bitmap allocator.
// ---------------------------------------------------------------------------
package sba_pkg;

   localparam int NUM_SLOTS = 80;
   localparam int IDX_W     = $clog2(NUM_SLOTS);
   localparam int MARK_W    = $clog2(NUM_SLOTS + 1);

   localparam int REQ_IDX_W  = 8;
   localparam int SLOT_W     = 7;
   localparam int HW_W       = 7;

   localparam int REQ_USER_W = 2;
   localparam int START_LSB  = 0;
   localparam int DIR_BIT    = START_LSB + REQ_IDX_W;
   localparam int FREE_LSB   = DIR_BIT + 1;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [REQ_USER_W-1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_scan;
      logic scan_done;
   } dp_sts_type;

endpackage

[src/slot_bitmap_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slot_bitmap_allocator
// Free-slot allocator over a used-bit map with a high-water mark.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: tuser carries the action (allocate, free, clear all);
//   tdata carries start index, search direction and free index.
//   rsp channel: one item per request with the granted slot (zero unless
//   allocate) and the high-water mark after the request.
// Timing:
//   Free, clear-all and unused codes go from dispatch straight to commit,
//   as does allocate with start past the slot count. A searching allocate
//   probes 1 to 80 slots in the scan, which reads one used bit per cycle
//   from the map.
//   The next item is accepted the cycle after the result is committed.
// Reset:
//   Synchronous, active high. All slots free, mark zero, no item pending.
// Stall:
//   A result waits in the output register while rsp_tready is low; a new
//   item may be accepted meanwhile, but its commit holds until the output
//   register is taken.
// ---------------------------------------------------------------------------
module slot_bitmap_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] start_index, [8] search_down, [16:9] free_index, [23:17] zero
   input  logic [sba_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] action
   input  logic [sba_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [6:0] slot, [13:7] high_water, [15:14] zero
   output logic [sba_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import sba_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   sba_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[src/sba_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_datapath
// Used-bit memory, scan pipeline, high-water mark and result register.
// ---------------------------------------------------------------------------
`include "slot_bitmap_allocator_macros.svh"

module sba_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sba_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [sba_pkg::REQ_USER_W-1:0]   req_tuser,
   input  sba_pkg::dp_cmd_type              cmd,
   output sba_pkg::dp_sts_type              sts,
   output logic [sba_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import sba_pkg::*;

   // request fields
   action_type            action_ff;
   logic [REQ_IDX_W-1:0]  start_ff;
   logic                  down_ff;
   logic [REQ_IDX_W-1:0]  fidx_ff;

   // scan pipeline
   logic [IDX_W-1:0]      scan_idx_ff;
   logic                  issue_en_ff;
   logic [IDX_W-1:0]      probe_idx_ff;
   logic                  probe_last_ff;
   logic                  probe_vld_ff;
   logic                  rd_mem_ff;
   logic                  rd_valid_ff;
   logic                  probe_used;
   logic                  scan_end;
   logic                  rd_en;

   // state
   logic                  used_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  valid_ff;
   logic [NUM_SLOTS-1:0]  valid_in;
   logic [MARK_W-1:0]     mark_ff;
   logic [MARK_W-1:0]     mark_in;
   logic [IDX_W-1:0]      slot_ff;

   // commit
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_data;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [SLOT_W-1:0]     rsp_slot_in;
   logic [HW_W-1:0]       rsp_mark_ff;

   assign probe_used = rd_valid_ff & rd_mem_ff;
   assign scan_end   = down_ff ? (scan_idx_ff == '0)
                               : (scan_idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign rd_en      = cmd.scan && issue_en_ff;

   assign sts.is_scan   = (action_ff == ACT_ALLOC) && (start_ff < REQ_IDX_W'(NUM_SLOTS));
   assign sts.scan_done = probe_vld_ff && (!probe_used || probe_last_ff);

   assign rsp_tdata = RSP_DATA_W'({rsp_mark_ff, rsp_slot_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action_type'(req_tuser);
         start_ff  <= req_tdata[START_LSB +: REQ_IDX_W];
         down_ff   <= req_tdata[DIR_BIT];
         fidx_ff   <= req_tdata[FREE_LSB +: REQ_IDX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_en_ff  <= 1'b0;
         probe_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         issue_en_ff  <= 1'b1;
         probe_vld_ff <= 1'b0;
      end else if (cmd.scan) begin
         probe_vld_ff <= issue_en_ff;
         if (issue_en_ff && scan_end) begin
            issue_en_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_idx_ff <= req_tdata[START_LSB +: IDX_W];
      end else if (rd_en && !scan_end) begin
         scan_idx_ff <= down_ff ? scan_idx_ff - IDX_W'(1) : scan_idx_ff + IDX_W'(1);
      end
      if (rd_en) begin
         probe_idx_ff  <= scan_idx_ff;
         probe_last_ff <= scan_end;
         rd_valid_ff   <= valid_ff[scan_idx_ff];
      end
      if (cmd.load) begin
         slot_ff <= IDX_W'(NUM_SLOTS - 1);
      end else if (cmd.scan && sts.scan_done) begin
         slot_ff <= probe_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         used_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_mem_ff <= used_mem[scan_idx_ff];
      end
   end

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = 1'b1;
      valid_in    = valid_ff;
      mark_in     = mark_ff;
      rsp_slot_in = '0;
      case (action_ff)
         ACT_ALLOC: begin
            wr_en             = 1'b1;
            valid_in[slot_ff] = 1'b1;
            rsp_slot_in       = SLOT_W'(slot_ff);
            if (MARK_W'(slot_ff) >= mark_ff) begin
               mark_in = MARK_W'(slot_ff) + MARK_W'(1);
            end
         end
         ACT_FREE: begin
            if ((fidx_ff < REQ_IDX_W'(mark_ff)) && (fidx_ff < REQ_IDX_W'(NUM_SLOTS))) begin
               wr_en   = 1'b1;
               wr_addr = fidx_ff[IDX_W-1:0];
               wr_data = 1'b0;
               if (fidx_ff + REQ_IDX_W'(1) == REQ_IDX_W'(mark_ff)) begin
                  mark_in = MARK_W'(fidx_ff);
               end
            end
         end
         ACT_CLEAR: begin
            valid_in = '0;
            mark_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mark_ff  <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_ff <= rsp_slot_in;
         rsp_mark_ff <= HW_W'(mark_in);
      end
   end

   `SBA_ASSERT(a_mark_range, clock, reset, mark_ff <= MARK_W'(NUM_SLOTS), "mark beyond slot count")
   `SBA_ASSERT(a_probe_range, clock, reset, probe_vld_ff |-> (probe_idx_ff < IDX_W'(NUM_SLOTS)), "probe index out of range")
   `SBA_ASSERT(a_alloc_mark, clock, reset, (cmd.commit && action_ff == ACT_ALLOC) |=> (mark_ff > MARK_W'($past(slot_ff))), "mark not above granted slot")

endmodule

[src/sba_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sba_ctrl
// Sequencer for the allocator: accept, dispatch, scan, commit.
// ---------------------------------------------------------------------------
`include "slot_bitmap_allocator_macros.svh"

module sba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output sba_pkg::dp_cmd_type  cmd,
   input  sba_pkg::dp_sts_type  sts
);
   import sba_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_tvalid_ff;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = sts.is_scan ? ST_SCAN : ST_COMMIT;
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.commit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   `SBA_ASSERT_NEVER(a_commit_over_full, clock, reset, cmd.commit && rsp_tvalid_ff && !rsp_tready, "commit over unread item")
   `SBA_ASSERT(a_valid_from_commit, clock, reset, $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_COMMIT), "item raised outside commit")

endmodule

[sim/slot_bitmap_allocator_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slot_bitmap_allocator_tb
// Self-checking bench for the slot bitmap allocator. It sends directed and
// random allocate, free, clear-all and unused-code items. The sender runs in
// bursts and the receiver stalls. The bench mirrors the used-bit map and the
// high-water mark, and checks every result item in order.
// ---------------------------------------------------------------------------
module slot_bitmap_allocator_tb;
   import sba_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_TAIL     = 120;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic [HW_W-1:0]   high_water;
   } grant_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [NUM_SLOTS-1:0] slot_used = '0;
   int                   high_mark = 0;
   grant_type            grant_q[$];
   int                   fail_count  = 0;
   int                   idle_cycles = 0;
   int                   burst_left  = 0;
   int                   gap_max     = 0;
   int                   stall_max   = 0;
   int                   hold_left   = 0;

   slot_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // grant and mark after one item, updating the mirrored map
   function automatic grant_type predict_grant(input logic [1:0] act, input logic [7:0] start,
                                               input logic toward_lower,
                                               input logic [7:0] fidx);
      grant_type g;
      int        k;
      int        pick;
      pick = 0;
      if (act == ACT_ALLOC) begin
         if (start >= NUM_SLOTS) begin
            pick = NUM_SLOTS - 1;
         end else if (!toward_lower) begin
            pick = NUM_SLOTS - 1;
            for (k = NUM_SLOTS - 1; k >= int'(start); k--)
               if (!slot_used[k]) pick = k;
         end else begin
            pick = 0;
            for (k = 0; k <= int'(start); k++)
               if (!slot_used[k]) pick = k;
         end
         slot_used[pick] = 1'b1;
         if (pick >= high_mark) high_mark = pick + 1;
      end else if (act == ACT_FREE) begin
         if (int'(fidx) < high_mark && int'(fidx) < NUM_SLOTS) begin
            if (int'(fidx) + 1 == high_mark) high_mark = int'(fidx);
            slot_used[fidx] = 1'b0;
         end
      end else if (act == ACT_CLEAR) begin
         slot_used = '0;
         high_mark = 0;
      end
      g.slot       = SLOT_W'(pick);
      g.high_water = HW_W'(high_mark);
      return g;
   endfunction

   task automatic send_item(input logic [1:0] act, input logic [7:0] start,
                            input logic toward_lower, input logic [7:0] fidx);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, fidx, toward_lower, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      grant_q.push_back(predict_grant(act, start, toward_lower, fidx));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 10);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_actions();
      send_item(ACT_FREE, 8'd0, 1'b0, 8'd0);
      send_item(ACT_UNUSED, 8'hFF, 1'b1, 8'hFF);
      send_item(ACT_CLEAR, 8'd0, 1'b0, 8'd0);
      wait_all_results();
   endtask

   task automatic test_allocate();
      send_item(ACT_ALLOC, 8'd0, 1'b0, 8'd0);
      send_item(ACT_ALLOC, 8'd0, 1'b0, 8'd0);
      send_item(ACT_ALLOC, 8'd255, 1'b0, 8'd0);
      send_item(ACT_ALLOC, 8'd128, 1'b1, 8'd0);
      send_item(ACT_ALLOC, 8'd79, 1'b1, 8'd0);
      // map holds 0, 1, 78, 79: both searches run out and fall back
      send_item(ACT_ALLOC, 8'd1, 1'b1, 8'd0);
      send_item(ACT_ALLOC, 8'd78, 1'b0, 8'd0);
      wait_all_results();
   endtask

   task automatic test_free();
      send_item(ACT_FREE, 8'd0, 1'b0, 8'd255);
      send_item(ACT_FREE, 8'd0, 1'b0, 8'd100);
      send_item(ACT_FREE, 8'd0, 1'b0, 8'd79);
      send_item(ACT_FREE, 8'd0, 1'b0, 8'd79);
      send_item(ACT_FREE, 8'd0, 1'b0, 8'd0);
      send_item(ACT_FREE, 8'd0, 1'b0, 8'd78);
      wait_all_results();
   endtask

   task automatic test_clear();
      send_item(ACT_CLEAR, 8'd0, 1'b0, 8'd0);
      send_item(ACT_ALLOC, 8'd40, 1'b0, 8'd0);
      send_item(ACT_CLEAR, 8'd0, 1'b0, 8'd0);
      send_item(ACT_ALLOC, 8'd40, 1'b1, 8'd0);
      wait_all_results();
   endtask

   task automatic test_random(input int count, input int gaps, input int stalls);
      int         i;
      int         r;
      logic [1:0] act;
      logic [7:0] start;
      logic [7:0] fidx;
      gap_max   = gaps;
      stall_max = stalls;
      for (i = 0; i < count; i++) begin
         r     = $urandom_range(0, 999);
         start = (($urandom_range(0, 9)) == 0) ? 8'($urandom_range(NUM_SLOTS, 255))
                                               : 8'($urandom_range(0, NUM_SLOTS - 1));
         fidx  = 8'($urandom_range(0, 255));
         if (r < 600) begin
            act = ACT_ALLOC;
         end else if (r < 900) begin
            act = ACT_FREE;
            r   = $urandom_range(0, 9);
            if (high_mark > 0 && r < 7) fidx = 8'($urandom_range(0, high_mark - 1));
            else if (high_mark > 0 && r < 9) fidx = 8'(high_mark - 1);
         end else if (r < 905) begin
            act = ACT_CLEAR;
         end else if (r < 925) begin
            act = ACT_UNUSED;
         end else begin
            act   = ACT_ALLOC;
            start = 8'($urandom_range(NUM_SLOTS, 255));
         end
         send_item(act, start, 1'($urandom_range(0, 1)), fidx);
      end
      wait_all_results();
   endtask

   always @(posedge clock) begin
      if (stall_max == 0) begin
         rsp_tready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
      end else begin
         rsp_tready <= !rsp_tready;
         hold_left = rsp_tready ? $urandom_range(0, 12) : $urandom_range(0, stall_max);
      end
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grant_q.size() == 0) begin
            $error("result item with none expected: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = grant_q.pop_front();
            if (rsp_tdata[SLOT_W-1:0] !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_tdata[SLOT_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[SLOT_W +: HW_W] !== want.high_water) begin
               $error("high_water: expected %0d, actual %0d",
                      want.high_water, rsp_tdata[SLOT_W +: HW_W]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_actions();
      test_allocate();
      test_free();
      test_clear();
      test_random(500, 0, 0);
      test_random(500, 6, 0);
      test_random(500, 0, 20);
      test_random(500, 8, 30);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
